FILE: design/rhsc_pkg.sv
// Shared types and constants for the rolling-hash substring counter.
// No dependencies; every other file of the block but rhsc_fifo refers to this package.
`timescale 1ns / 1ps

package rhsc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PAT_BYTES = 16;
  // Register stages of the hash unit, from window bytes to reduced hash.
  localparam int unsigned HASH_LAT  = 6;
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_e;

  // Classification of one text item, made by the front end.
  typedef struct packed {
    logic win_full;
    logic last;
  } ent_ctl_t;

  // Control that travels alongside the hash pipeline in the back end.
  typedef struct packed {
    logic win_full;
    logic last;
    logic eq;
  } side_t;

  typedef struct packed {
    logic               hash_hit;
    logic               window_match;
    logic [COUNT_W-1:0] match_count;
    logic               end_of_text;
  } res_t;

endpackage

FILE: design/rhsc_fifo.sv
// Small register-based queue used between the front and back ends and on the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rhsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/rhsc_front.sv
// Front end: configuration registers, text window shift register and fill tracking.
// Classifies each accepted item and prepares the reversed pattern; uses rhsc_pkg.
`timescale 1ns / 1ps

module rhsc_front #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_we_i,
  input  logic [rhsc_pkg::CFG_IDX_W-1:0]                    cfg_idx_i,
  input  logic [rhsc_pkg::CFG_W-1:0]                        cfg_data_i,
  input  logic                                              accept_i,
  input  logic [rhsc_pkg::BYTE_W-1:0]                       text_byte_i,
  input  logic                                              last_i,
  output logic [MAX_PATTERN-1:0][rhsc_pkg::BYTE_W-1:0]      ent_bytes_o,
  output rhsc_pkg::ent_ctl_t                                ent_ctl_o,
  output logic [MAX_PATTERN-1:0][rhsc_pkg::BYTE_W-1:0]      rp_o
);

  localparam int unsigned LEN_W  = rhsc_pkg::LEN_W;
  localparam int unsigned BYTE_W = rhsc_pkg::BYTE_W;

  logic [LEN_W-1:0]                        plen_q;
  logic [rhsc_pkg::CFG_W-1:0]              pat_lo_q, pat_hi_q;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0]      win_q, win_d;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0]      rp_q, rp_d;
  logic [LEN_W-1:0]                        fill_q, fill_next;
  logic [LEN_W-1:0]                        eff_len;
  logic [rhsc_pkg::PAT_BYTES-1:0][BYTE_W-1:0] pat_vec;
  logic                                    restart;

  assign pat_vec = {pat_hi_q, pat_lo_q};

  // Length zero reads as one, lengths above the window depth as the depth.
  always_comb begin
    if (plen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(plen_q) > int'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = plen_q;
    end
  end

  // Lane k of the window holds the byte k items back; pattern byte L-1-k belongs there.
  always_comb begin
    logic [LEN_W-1:0] j;
    for (int k = 0; k < int'(MAX_PATTERN); k++) begin
      j        = eff_len - LEN_W'(1) - LEN_W'(k);
      rp_d[k]  = '0;
      if (int'(eff_len) > k && j < LEN_W'(rhsc_pkg::PAT_BYTES)) begin
        rp_d[k] = pat_vec[j[3:0]];
      end
    end
  end

  always_comb begin
    win_d[0] = text_byte_i;
    for (int k = 1; k < int'(MAX_PATTERN); k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign fill_next = (fill_q < eff_len) ? fill_q + LEN_W'(1) : fill_q;

  always_comb begin
    for (int k = 0; k < int'(MAX_PATTERN); k++) begin
      ent_bytes_o[k] = (int'(eff_len) > k) ? win_d[k] : '0;
    end
    ent_ctl_o.win_full = (fill_next >= eff_len);
    ent_ctl_o.last     = last_i;
  end

  assign rp_o = rp_q;

  assign restart = cfg_we_i &&
                   (rhsc_pkg::cfg_reg_e'(cfg_idx_i) inside {rhsc_pkg::REG_PATTERN_LENGTH,
                                                             rhsc_pkg::REG_PATTERN_LOW,
                                                             rhsc_pkg::REG_PATTERN_HIGH});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= LEN_W'(1);
      pat_lo_q <= '0;
      pat_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rhsc_pkg::cfg_reg_e'(cfg_idx_i))
        rhsc_pkg::REG_PATTERN_LENGTH: plen_q   <= cfg_data_i[LEN_W-1:0];
        rhsc_pkg::REG_PATTERN_LOW:    pat_lo_q <= cfg_data_i;
        rhsc_pkg::REG_PATTERN_HIGH:   pat_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rp_q   <= '0;
    end else begin
      rp_q <= rp_d;
      if (restart) begin
        fill_q <= '0;
      end else if (accept_i) begin
        fill_q <= last_i ? '0 : fill_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

FILE: design/rhsc_hash.sv
// Pipelined modular hash of a byte window: lane products, registered adder tree,
// then reduction by the modulus through a reciprocal multiply. Uses rhsc_pkg.
`timescale 1ns / 1ps

module rhsc_hash #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned RADIX       = 256,
  parameter int unsigned MODULUS     = 101
) (
  input  logic                                         clk_i,
  input  logic [MAX_PATTERN-1:0][rhsc_pkg::BYTE_W-1:0] bytes_i,
  output logic [$clog2(MODULUS)-1:0]                   hash_o
);

  localparam int unsigned HW    = $clog2(MODULUS);
  localparam int unsigned PW    = rhsc_pkg::BYTE_W + HW;
  localparam int unsigned NG    = (MAX_PATTERN + 7) / 8;
  localparam int unsigned LANES = NG * 8;
  localparam int unsigned GW    = PW + 3;
  localparam int unsigned SW    = GW + $clog2(NG);
  localparam longint unsigned RECIP = (64'd1 << SW) / MODULUS;

  // Weight of lane k is RADIX^k reduced by the modulus.
  function automatic int unsigned pow_mod(int unsigned k);
    int unsigned p;
    p = 1 % MODULUS;
    for (int unsigned i = 0; i < k; i++) begin
      p = (p * RADIX) % MODULUS;
    end
    return p;
  endfunction

  logic [LANES-1:0][PW-1:0] prod_q;
  logic [NG-1:0][GW-1:0]    grp_d, grp_q;
  logic [SW-1:0]            sum_d, sum_q;
  logic [2*SW-1:0]          qprod;
  logic [SW-1:0]            q_q, x_q;
  logic [SW-1:0]            qm, diff;
  logic [HW:0]              rem_q;
  logic [HW-1:0]            hash_q;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < MAX_PATTERN) begin : g_used
      localparam int unsigned POW = pow_mod(k);
      always_ff @(posedge clk_i) begin
        prod_q[k] <= PW'(bytes_i[k]) * PW'(POW);
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        prod_q[k] <= '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < int'(NG); g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < 8; i++) begin
        grp_d[g] = grp_d[g] + GW'(prod_q[g*8+i]);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < int'(NG); g++) begin
      sum_d = sum_d + SW'(grp_q[g]);
    end
  end

  // The estimated quotient is exact or one short, so one subtract finishes the job.
  assign qprod = (2*SW)'(sum_q) * (2*SW)'(RECIP);
  assign qm    = SW'(q_q * SW'(MODULUS));
  assign diff  = x_q - qm;

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    sum_q  <= sum_d;
    q_q    <= qprod[2*SW-1:SW];
    x_q    <= sum_q;
    rem_q  <= diff[HW:0];
    hash_q <= (rem_q >= (HW+1)'(MODULUS)) ? HW'(rem_q - (HW+1)'(MODULUS)) : HW'(rem_q);
  end

  assign hash_o = hash_q;

endmodule

FILE: design/rhsc_back.sv
// Back end: hashes the window and the pattern, compares them, and keeps the match count.
// Issues from the middle queue against credit in the result queue; uses rhsc_pkg, rhsc_hash.
`timescale 1ns / 1ps

module rhsc_back #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned RADIX       = 256,
  parameter int unsigned MODULUS     = 101
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             mid_empty_i,
  input  logic [MAX_PATTERN-1:0][rhsc_pkg::BYTE_W-1:0]     head_bytes_i,
  input  rhsc_pkg::ent_ctl_t                               head_ctl_i,
  output logic                                             mid_pop_o,
  input  logic [MAX_PATTERN-1:0][rhsc_pkg::BYTE_W-1:0]     rp_i,
  input  logic [$clog2(rhsc_pkg::OUT_DEPTH+1)-1:0]         out_count_i,
  output logic                                             res_push_o,
  output rhsc_pkg::res_t                                   res_o
);

  localparam int unsigned HW      = $clog2(MODULUS);
  localparam int unsigned LAT     = rhsc_pkg::HASH_LAT;
  localparam int unsigned IFW     = $clog2(rhsc_pkg::OUT_DEPTH + 1);
  localparam int unsigned COUNT_W = rhsc_pkg::COUNT_W;

  logic [HW-1:0]               win_hash, pat_hash;
  logic                        issue, retire;
  logic [LAT-1:0]              vld_q;
  rhsc_pkg::side_t [LAT-1:0]   side_q;
  rhsc_pkg::side_t             side_in, side_out;
  logic [IFW-1:0]              inflight_q;
  logic [COUNT_W-1:0]          cnt_q, cnt_next;
  logic                        hit, match;

  rhsc_hash #(
    .MAX_PATTERN (MAX_PATTERN),
    .RADIX       (RADIX),
    .MODULUS     (MODULUS)
  ) u_win_hash (
    .clk_i   (clk_i),
    .bytes_i (head_bytes_i),
    .hash_o  (win_hash)
  );

  rhsc_hash #(
    .MAX_PATTERN (MAX_PATTERN),
    .RADIX       (RADIX),
    .MODULUS     (MODULUS)
  ) u_pat_hash (
    .clk_i   (clk_i),
    .bytes_i (rp_i),
    .hash_o  (pat_hash)
  );

  // Every item in flight owns a result queue slot before it is issued.
  assign issue = !mid_empty_i &&
                 (({1'b0, out_count_i} + {1'b0, inflight_q}) < (IFW+1)'(rhsc_pkg::OUT_DEPTH));
  assign mid_pop_o = issue;

  // Lanes beyond the pattern length are zero on both sides, so a whole-vector compare works.
  assign side_in.win_full = head_ctl_i.win_full;
  assign side_in.last     = head_ctl_i.last;
  assign side_in.eq       = (head_bytes_i == rp_i);

  assign retire   = vld_q[LAT-1];
  assign side_out = side_q[LAT-1];
  assign hit      = side_out.win_full && (win_hash == pat_hash);
  assign match    = hit && side_out.eq;
  assign cnt_next = (match && cnt_q != '1) ? cnt_q + COUNT_W'(1) : cnt_q;

  assign res_push_o         = retire;
  assign res_o.hash_hit     = hit;
  assign res_o.window_match = match;
  assign res_o.match_count  = cnt_next;
  assign res_o.end_of_text  = side_out.last;

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int s = 1; s < int'(LAT); s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      inflight_q <= '0;
      cnt_q      <= '0;
    end else begin
      vld_q      <= {vld_q[LAT-2:0], issue};
      inflight_q <= inflight_q + IFW'(issue) - IFW'(retire);
      if (retire) begin
        cnt_q <= side_out.last ? '0 : cnt_next;
      end
    end
  end

endmodule

FILE: design/rolling_hash_substring_counter_core.sv
// Top level of the rolling-hash substring counter: front end, middle queue, back end
// and result queue. Uses rhsc_pkg, rhsc_front, rhsc_fifo and rhsc_back.
`timescale 1ns / 1ps

// Counts exact, possibly overlapping occurrences of a pattern of up to MAX_PATTERN bytes in a
// byte stream. Each text item pushed gives one result: a hash-hit flag, a match flag for the
// window ending at that byte, the saturating running count and an end-of-text flag; the count
// clears after the item marked last. The block takes one item per clock while full is low and
// delivers one result per clock when pop is held high and empty is low. A result reaches the
// output through the middle queue, the six register stages of the hash unit (products, two adder
// levels and the three-step reduction by the modulus) and the result queue. Configuration writes
// restart the window; give them while no item is in flight after the last push, and push the
// next item no earlier than the cycle after the write.
module rolling_hash_substring_counter_core #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned RADIX       = 256,
  parameter int unsigned MODULUS     = 101
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rhsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rhsc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [rhsc_pkg::BYTE_W-1:0]         text_byte_i,
  input  logic                                last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                hash_hit_o,
  output logic                                window_match_o,
  output logic [rhsc_pkg::COUNT_W-1:0]        match_count_o,
  output logic                                end_of_text_o
);

  localparam int unsigned BYTE_W = rhsc_pkg::BYTE_W;
  localparam int unsigned MID_W  = MAX_PATTERN * BYTE_W + $bits(rhsc_pkg::ent_ctl_t);
  localparam int unsigned RES_W  = $bits(rhsc_pkg::res_t);
  localparam int unsigned OCW    = $clog2(rhsc_pkg::OUT_DEPTH + 1);

  logic                               in_acc;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] ent_bytes, head_bytes, rp;
  rhsc_pkg::ent_ctl_t                 ent_ctl, head_ctl;
  logic [MID_W-1:0]                   mid_rdata;
  logic                               mid_empty, mid_pop;
  logic                               res_push, out_full;
  rhsc_pkg::res_t                     res_in, res_out;
  logic [RES_W-1:0]                   out_rdata;
  logic [OCW-1:0]                     out_count;

  assign in_acc = push && !full;

  rhsc_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_acc),
    .text_byte_i (text_byte_i),
    .last_i      (last_i),
    .ent_bytes_o (ent_bytes),
    .ent_ctl_o   (ent_ctl),
    .rp_o        (rp)
  );

  rhsc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (rhsc_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .wdata_i ({ent_bytes, ent_ctl}),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (full),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign {head_bytes, head_ctl} = mid_rdata;

  rhsc_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .RADIX       (RADIX),
    .MODULUS     (MODULUS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .head_bytes_i (head_bytes),
    .head_ctl_i   (head_ctl),
    .mid_pop_o    (mid_pop),
    .rp_i         (rp),
    .out_count_i  (out_count),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  rhsc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (rhsc_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign res_out        = rhsc_pkg::res_t'(out_rdata);
  assign hash_hit_o     = res_out.hash_hit;
  assign window_match_o = res_out.window_match;
  assign match_count_o  = res_out.match_count;
  assign end_of_text_o  = res_out.end_of_text;

  // The credit check in the back end must keep the result queue from overflowing.
  a_no_result_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_push |-> !out_full
  ) else $error("result pushed into a full result queue");

  a_issue_from_filled_queue: assert property (
    @(posedge clk_i) disable iff (!rst_ni) mid_pop |-> !mid_empty
  ) else $error("back end issued from an empty middle queue");

  a_match_needs_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (!empty && window_match_o) |-> hash_hit_o
  ) else $error("window match reported without a hash hit");

  a_match_counted: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (!empty && window_match_o) |-> (match_count_o != '0)
  ) else $error("window match reported with a zero count");

endmodule
